@@ rtl/tmmc_pkg.sv @@
package tmmc_pkg;

  localparam int OCF_QUEUE_DEPTH = 16;
  localparam int OCF_PTR_W       = (OCF_QUEUE_DEPTH > 1) ? $clog2(OCF_QUEUE_DEPTH) : 1;
  localparam int OCF_FILL_W      = $clog2(OCF_QUEUE_DEPTH + 1);
  localparam int OCF_WORD_W      = 32;

  localparam int OP_FIFO_DEPTH = 2;
  localparam int OP_PTR_W      = (OP_FIFO_DEPTH > 1) ? $clog2(OP_FIFO_DEPTH) : 1;
  localparam int OP_CNT_W      = $clog2(OP_FIFO_DEPTH + 1);

  localparam int SCID_W  = 10;
  localparam int COUNT_W = 8;
  localparam int VCID_W  = 3;
  localparam int NUM_VC  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPACECRAFT_ID      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OCF_ENABLED        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VC_CONFIGURED_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OCF_SINK_CONNECTED = 3'd3;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  typedef struct packed {
    logic [SCID_W-1:0] spacecraft_id;
    logic              ocf_enabled;
    logic [NUM_VC-1:0] vc_configured_mask;
    logic              ocf_sink_connected;
  } cfg_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    logic                  is_pop;
    logic                  scid_ok;
    logic [COUNT_W-1:0]    lost_frames;
    logic                  wrong_ocf_flag;
    logic                  want_ocf;
    logic                  route_valid;
    logic [VCID_W-1:0]     route_vcid;
    logic                  unconfigured;
    logic [OCF_WORD_W-1:0] ocf_word;
  } op_t;

  typedef struct packed {
    logic               wrong_scid;
    logic [COUNT_W-1:0] lost_frames;
    logic               wrong_ocf_flag;
    logic               ocf_queued;
    logic               ocf_overflow;
    logic               no_ocf_sink;
    logic [VCID_W-1:0]  unconfigured_vc;
    logic               route_valid;
    logic [VCID_W-1:0]  route_vcid;
    logic               ocf_out_valid;
    logic               ocf_empty_error;
  } res_t;

endpackage

@@ rtl/tmmc_ram.sv @@
module tmmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tmmc_front.sv @@
module tmmc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [tmmc_pkg::SCID_W-1:0]       frame_scid_i,
  input  logic [tmmc_pkg::COUNT_W-1:0]      frame_mc_count_i,
  input  logic                              frame_ocf_flag_i,
  input  logic [tmmc_pkg::VCID_W-1:0]       frame_vcid_i,
  input  logic [tmmc_pkg::OCF_WORD_W-1:0]   frame_ocf_word_i,
  input  tmmc_pkg::cfg_t                    cfg_i,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output tmmc_pkg::op_t                     op_o
);
  import tmmc_pkg::*;

  logic [COUNT_W-1:0] exp_count_q, exp_count_d;
  logic               accept;
  op_t                op;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  always_comb begin
    op = '0;
    if (command_i == CMD_POP) begin
      op.is_pop = 1'b1;
    end else if (frame_scid_i == cfg_i.spacecraft_id) begin
      op.scid_ok        = 1'b1;
      op.lost_frames    = frame_mc_count_i - exp_count_q;
      op.wrong_ocf_flag = frame_ocf_flag_i != cfg_i.ocf_enabled;
      op.want_ocf       = cfg_i.ocf_enabled && frame_ocf_flag_i;
      op.ocf_word       = frame_ocf_word_i;
      if (cfg_i.vc_configured_mask[frame_vcid_i]) begin
        op.route_valid = 1'b1;
        op.route_vcid  = frame_vcid_i;
      end else begin
        op.unconfigured = 1'b1;
      end
    end
  end

  // Resync to the received count on every frame of our spacecraft.
  always_comb begin
    exp_count_d = exp_count_q;
    if (accept && op.scid_ok) begin
      exp_count_d = frame_mc_count_i + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_count_q <= '0;
    end else begin
      exp_count_q <= exp_count_d;
    end
  end

  assign push_o = accept;
  assign op_o   = op;

endmodule

@@ rtl/tmmc_op_fifo.sv @@
module tmmc_op_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tmmc_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tmmc_pkg::op_t op_o
);
  import tmmc_pkg::*;

  op_t                 mem_q [OP_FIFO_DEPTH];
  logic [OP_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OP_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == OP_CNT_W'(OP_FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == OP_PTR_W'(OP_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + OP_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == OP_PTR_W'(OP_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + OP_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + OP_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - OP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ rtl/tmmc_back.sv @@
module tmmc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            op_valid_i,
  input  tmmc_pkg::op_t                   op_i,
  output logic                            op_pop_o,
  input  tmmc_pkg::cfg_t                  cfg_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tmmc_pkg::res_t                  res_o,
  output logic [tmmc_pkg::OCF_WORD_W-1:0] ocf_out_o
);
  import tmmc_pkg::*;

  logic [OCF_PTR_W-1:0]  rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [OCF_FILL_W-1:0] fill_q, fill_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q, res_d;
  logic                  advance, can_pop, can_push, do_read, do_write;
  logic [OCF_WORD_W-1:0] rdata;

  assign advance  = op_valid_i && (!out_valid_q || !out_stall_i);
  assign can_pop  = fill_q != '0;
  assign can_push = fill_q < OCF_FILL_W'(OCF_QUEUE_DEPTH);
  assign do_read  = advance && op_i.is_pop && can_pop;
  assign do_write = advance && !op_i.is_pop && op_i.want_ocf && can_push;

  always_comb begin
    res_d = '0;
    if (op_i.is_pop) begin
      res_d.ocf_out_valid   = can_pop;
      res_d.ocf_empty_error = !can_pop;
    end else if (!op_i.scid_ok) begin
      res_d.wrong_scid = 1'b1;
    end else begin
      res_d.lost_frames     = op_i.lost_frames;
      res_d.wrong_ocf_flag  = op_i.wrong_ocf_flag;
      res_d.ocf_queued      = op_i.want_ocf && can_push;
      res_d.ocf_overflow    = op_i.want_ocf && !can_push;
      res_d.no_ocf_sink     = op_i.want_ocf && can_push && !cfg_i.ocf_sink_connected;
      res_d.unconfigured_vc = {{(VCID_W-1){1'b0}}, op_i.unconfigured};
      res_d.route_valid     = op_i.route_valid;
      res_d.route_vcid      = op_i.route_vcid;
    end
  end

  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    if (do_read) begin
      rd_ptr_d = (rd_ptr_q == OCF_PTR_W'(OCF_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + OCF_PTR_W'(1);
      fill_d   = fill_q - OCF_FILL_W'(1);
    end
    if (do_write) begin
      wr_ptr_d = (wr_ptr_q == OCF_PTR_W'(OCF_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + OCF_PTR_W'(1);
      fill_d   = fill_q + OCF_FILL_W'(1);
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  tmmc_ram #(
    .WIDTH (OCF_WORD_W),
    .DEPTH (OCF_QUEUE_DEPTH)
  ) u_ocf_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_ptr_q),
    .wdata_i (op_i.ocf_word),
    .re_i    (do_read),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign op_pop_o    = advance;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign ocf_out_o   = res_q.ocf_out_valid ? rdata : '0;

`ifndef NO_ASSERTIONS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= OCF_FILL_W'(OCF_QUEUE_DEPTH))
    else $error("OCF fill exceeds queue depth");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("OCF queue empty with pointers apart");

  a_pop_no_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ocf_out_valid) |->
      !(res_q.route_valid || res_q.ocf_queued || res_q.wrong_scid))
    else $error("pop result carries frame fields");

  a_queue_xor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ocf_queued) |-> !res_q.ocf_overflow)
    else $error("OCF both queued and overflowed");

  a_sink_needs_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.ocf_queued) |-> !res_q.no_ocf_sink)
    else $error("missing sink flagged without a queued word");
`endif

endmodule

@@ rtl/tm_master_channel_rx_checker.sv @@
// Path: an accepted transaction is registered in the operation FIFO, then in the output register.
// Throughput: one transaction per cycle while the output is not stalled, the OCF queue state in
//   the back end then being updated once per cycle. An output stall holds the back end, fills the
//   operation FIFO and so stalls the input as long as the output stalled, with no extra bubble.
// Reset: asynchronous, active low; clears frame count, queue pointers/fills and out_valid, and
//   loads configuration defaults. OCF RAM contents are undefined until written.
module tm_master_channel_rx_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // frame header / pop transaction in
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic [tmmc_pkg::SCID_W-1:0]            frame_scid_i,
  input  logic [tmmc_pkg::COUNT_W-1:0]           frame_mc_count_i,
  input  logic                                   frame_ocf_flag_i,
  input  logic [tmmc_pkg::VCID_W-1:0]            frame_vcid_i,
  input  logic [tmmc_pkg::OCF_WORD_W-1:0]        frame_ocf_word_i,
  // result transaction out
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   wrong_scid_o,
  output logic [tmmc_pkg::COUNT_W-1:0]           lost_frames_o,
  output logic                                   wrong_ocf_flag_o,
  output logic                                   ocf_queued_o,
  output logic                                   ocf_overflow_o,
  output logic                                   no_ocf_sink_o,
  output logic [tmmc_pkg::VCID_W-1:0]            unconfigured_vc_o,
  output logic                                   route_valid_o,
  output logic [tmmc_pkg::VCID_W-1:0]            route_vcid_o,
  output logic [tmmc_pkg::OCF_WORD_W-1:0]        ocf_out_o,
  output logic                                   ocf_out_valid_o,
  output logic                                   ocf_empty_error_o,
  // configuration write
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tmmc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tmmc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import tmmc_pkg::*;

  cfg_t cfg_q, cfg_d;
  op_t  front_op, fifo_op;
  res_t res;
  logic push, fifo_full, fifo_valid, fifo_pop;

  // Configuration registers: always ready, ignore indexes beyond the list.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_SPACECRAFT_ID:      cfg_d.spacecraft_id      = cfg_data_i[SCID_W-1:0];
        CFG_IDX_OCF_ENABLED:        cfg_d.ocf_enabled        = cfg_data_i[0];
        CFG_IDX_VC_CONFIGURED_MASK: cfg_d.vc_configured_mask = cfg_data_i[NUM_VC-1:0];
        CFG_IDX_OCF_SINK_CONNECTED: cfg_d.ocf_sink_connected = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacecraft_id      <= '0;
      cfg_q.ocf_enabled        <= 1'b1;
      cfg_q.vc_configured_mask <= NUM_VC'(8'h80);  // idle channel 7 only
      cfg_q.ocf_sink_connected <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify, track the frame count.
  tmmc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .frame_scid_i     (frame_scid_i),
    .frame_mc_count_i (frame_mc_count_i),
    .frame_ocf_flag_i (frame_ocf_flag_i),
    .frame_vcid_i     (frame_vcid_i),
    .frame_ocf_word_i (frame_ocf_word_i),
    .cfg_i            (cfg_q),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .op_o             (front_op)
  );

  // Decouple the two sides so each can stall on its own.
  tmmc_op_fifo u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .op_o    (fifo_op)
  );

  // Back: OCF queue push/pop and the output register.
  tmmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (fifo_valid),
    .op_i        (fifo_op),
    .op_pop_o    (fifo_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .ocf_out_o   (ocf_out_o)
  );

  assign wrong_scid_o      = res.wrong_scid;
  assign lost_frames_o     = res.lost_frames;
  assign wrong_ocf_flag_o  = res.wrong_ocf_flag;
  assign ocf_queued_o      = res.ocf_queued;
  assign ocf_overflow_o    = res.ocf_overflow;
  assign no_ocf_sink_o     = res.no_ocf_sink;
  assign unconfigured_vc_o = res.unconfigured_vc;
  assign route_valid_o     = res.route_valid;
  assign route_vcid_o      = res.route_vcid;
  assign ocf_out_valid_o   = res.ocf_out_valid;
  assign ocf_empty_error_o = res.ocf_empty_error;

endmodule

@@ bench/tm_master_channel_rx_checker_test.sv @@
`timescale 1ns / 100ps

module tm_master_channel_rx_checker_test;
  import tmmc_pkg::*;

  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int IDLE_PCT    = 16;

  // One transaction on the input channel, in port order.
  typedef struct packed {
    logic                  cmd;
    logic [SCID_W-1:0]     scid;
    logic [COUNT_W-1:0]    count;
    logic                  flag;
    logic [VCID_W-1:0]     vcid;
    logic [OCF_WORD_W-1:0] word;
  } mc_frame_t;

  // One transaction on the result channel, in port order.
  typedef struct packed {
    logic                  wrong_scid;
    logic [COUNT_W-1:0]    lost_frames;
    logic                  wrong_ocf_flag;
    logic                  ocf_queued;
    logic                  ocf_overflow;
    logic                  no_ocf_sink;
    logic [VCID_W-1:0]     unconfigured_vc;
    logic                  route_valid;
    logic [VCID_W-1:0]     route_vcid;
    logic [OCF_WORD_W-1:0] ocf_out;
    logic                  ocf_out_valid;
    logic                  ocf_empty_error;
  } mc_report_t;

  // Mirror of the master channel state; predicts one report per transaction.
  class mc_scoreboard;
    logic [SCID_W-1:0]     scid_reg;
    logic                  ocf_en_reg;
    logic [NUM_VC-1:0]     vc_mask_reg;
    logic                  sink_reg;
    logic [COUNT_W-1:0]    next_count;
    logic [OCF_WORD_W-1:0] ocf_fifo[$];
    mc_report_t            expected_reports[$];
    int errors, frames_seen, pops_seen, empty_pops, overflows, gaps, configs;

    function new();
      scid_reg    = '0;
      ocf_en_reg  = 1'b1;
      vc_mask_reg = 8'h80;
      sink_reg    = 1'b0;
      next_count  = '0;
      errors      = 0;
      frames_seen = 0;
      pops_seen   = 0;
      empty_pops  = 0;
      overflows   = 0;
      gaps        = 0;
      configs     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_SPACECRAFT_ID:      scid_reg    = data[SCID_W-1:0];
        CFG_IDX_OCF_ENABLED:        ocf_en_reg  = data[0];
        CFG_IDX_VC_CONFIGURED_MASK: vc_mask_reg = data[NUM_VC-1:0];
        CFG_IDX_OCF_SINK_CONNECTED: sink_reg    = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_input(mc_frame_t f);
      mc_report_t r;
      r = '0;
      if (f.cmd == CMD_POP) begin
        pops_seen++;
        if (ocf_fifo.size() == 0) begin
          r.ocf_empty_error = 1'b1;
          empty_pops++;
        end else begin
          r.ocf_out       = ocf_fifo.pop_front();
          r.ocf_out_valid = 1'b1;
        end
      end else if (f.scid != scid_reg) begin
        r.wrong_scid = 1'b1;
      end else begin
        frames_seen++;
        r.lost_frames = f.count - next_count;
        if (r.lost_frames != 0) gaps++;
        next_count = f.count + 1'b1;
        r.wrong_ocf_flag = (f.flag != ocf_en_reg);
        if (ocf_en_reg && f.flag) begin
          if (ocf_fifo.size() < OCF_QUEUE_DEPTH) begin
            ocf_fifo.push_back(f.word);
            r.ocf_queued  = 1'b1;
            r.no_ocf_sink = !sink_reg;
          end else begin
            r.ocf_overflow = 1'b1;
            overflows++;
          end
        end
        if (vc_mask_reg[f.vcid]) begin
          r.route_valid = 1'b1;
          r.route_vcid  = f.vcid;
        end else begin
          r.unconfigured_vc = VCID_W'(1);
        end
      end
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(mc_report_t act);
      mc_report_t exp_r;
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      exp_r = expected_reports.pop_front();
      compare_field("wrong_scid",      exp_r.wrong_scid,      act.wrong_scid);
      compare_field("lost_frames",     exp_r.lost_frames,     act.lost_frames);
      compare_field("wrong_ocf_flag",  exp_r.wrong_ocf_flag,  act.wrong_ocf_flag);
      compare_field("ocf_queued",      exp_r.ocf_queued,      act.ocf_queued);
      compare_field("ocf_overflow",    exp_r.ocf_overflow,    act.ocf_overflow);
      compare_field("no_ocf_sink",     exp_r.no_ocf_sink,     act.no_ocf_sink);
      compare_field("unconfigured_vc", exp_r.unconfigured_vc, act.unconfigured_vc);
      compare_field("route_valid",     exp_r.route_valid,     act.route_valid);
      compare_field("route_vcid",      exp_r.route_vcid,      act.route_vcid);
      compare_field("ocf_out",         exp_r.ocf_out,         act.ocf_out);
      compare_field("ocf_out_valid",   exp_r.ocf_out_valid,   act.ocf_out_valid);
      compare_field("ocf_empty_error", exp_r.ocf_empty_error, act.ocf_empty_error);
    endfunction
  endclass

  // Every input starts at a known value.
  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic                  command_i        = CMD_FRAME;
  logic [SCID_W-1:0]     frame_scid_i     = '0;
  logic [COUNT_W-1:0]    frame_mc_count_i = '0;
  logic                  frame_ocf_flag_i = 1'b0;
  logic [VCID_W-1:0]     frame_vcid_i     = '0;
  logic [OCF_WORD_W-1:0] frame_ocf_word_i = '0;
  logic                  out_stall_i      = 1'b0;
  logic                  cfg_valid_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i       = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  wrong_scid_o;
  logic [COUNT_W-1:0]    lost_frames_o;
  logic                  wrong_ocf_flag_o;
  logic                  ocf_queued_o;
  logic                  ocf_overflow_o;
  logic                  no_ocf_sink_o;
  logic [VCID_W-1:0]     unconfigured_vc_o;
  logic                  route_valid_o;
  logic [VCID_W-1:0]     route_vcid_o;
  logic [OCF_WORD_W-1:0] ocf_out_o;
  logic                  ocf_out_valid_o;
  logic                  ocf_empty_error_o;
  logic                  cfg_ready_o;

  mc_scoreboard sb;
  bit           rx_idle = 1'b1;

  tm_master_channel_rx_checker u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .frame_scid_i      (frame_scid_i),
    .frame_mc_count_i  (frame_mc_count_i),
    .frame_ocf_flag_i  (frame_ocf_flag_i),
    .frame_vcid_i      (frame_vcid_i),
    .frame_ocf_word_i  (frame_ocf_word_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .wrong_scid_o      (wrong_scid_o),
    .lost_frames_o     (lost_frames_o),
    .wrong_ocf_flag_o  (wrong_ocf_flag_o),
    .ocf_queued_o      (ocf_queued_o),
    .ocf_overflow_o    (ocf_overflow_o),
    .no_ocf_sink_o     (no_ocf_sink_o),
    .unconfigured_vc_o (unconfigured_vc_o),
    .route_valid_o     (route_valid_o),
    .route_vcid_o      (route_vcid_o),
    .ocf_out_o         (ocf_out_o),
    .ocf_out_valid_o   (ocf_out_valid_o),
    .ocf_empty_error_o (ocf_empty_error_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // 10 ns clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset from the start, release it on a falling edge, never assert it again.
  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Throttle the result side; rx_idle switches stalls off for a long stretch.
  always @(negedge clk_i) begin
    out_stall_i <= rx_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Sample both channels at the rising edge. A transaction is predicted the moment
  // it is accepted; a result is checked against the oldest prediction. A result
  // leaves only after its transaction has passed the operation FIFO and the output
  // register, so the two never refer to the same transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_input({command_i, frame_scid_i, frame_mc_count_i, frame_ocf_flag_i,
                       frame_vcid_i, frame_ocf_word_i});
      if (out_valid_o && !out_stall_i)
        sb.check_result({wrong_scid_o, lost_frames_o, wrong_ocf_flag_o, ocf_queued_o,
                         ocf_overflow_o, no_ocf_sink_o, unconfigured_vc_o, route_valid_o,
                         route_vcid_o, ocf_out_o, ocf_out_valid_o, ocf_empty_error_o});
    end
  end

  function automatic mc_frame_t make_frame(logic cmd, logic [SCID_W-1:0] scid,
                                           logic [COUNT_W-1:0] count, logic flag,
                                           logic [VCID_W-1:0] vcid,
                                           logic [OCF_WORD_W-1:0] word);
    mc_frame_t f;
    f.cmd   = cmd;
    f.scid  = scid;
    f.count = count;
    f.flag  = flag;
    f.vcid  = vcid;
    f.word  = word;
    return f;
  endfunction

  // Pops at pop_pct percent, else mostly well-formed frames: right spacecraft, next count in
  // sequence and the configured OCF flag, with a sprinkling of foreign IDs, count jumps and flag errors.
  function automatic mc_frame_t random_item(int pop_pct);
    mc_frame_t   f;
    logic [31:0] rnd;
    rnd = $urandom;
    f = make_frame(CMD_FRAME, sb.scid_reg, sb.next_count, sb.ocf_en_reg, rnd[2:0], $urandom);
    if ($urandom_range(0, 99) < pop_pct) begin
      // Frame fields are don't-care on a pop; scramble them anyway.
      f.cmd   = CMD_POP;
      f.scid  = rnd[12:3];
      f.count = rnd[20:13];
      f.flag  = rnd[21];
    end else begin
      if ($urandom_range(0, 99) < 6)  f.scid  = rnd[12:3];
      if ($urandom_range(0, 99) < 10) f.count = rnd[20:13];
      if ($urandom_range(0, 99) < 8)  f.flag  = ~f.flag;
    end
    return f;
  endfunction

  // Enter and leave on a falling edge. Valid stays high into the next transaction;
  // an idle gap lowers it here and raises it again on a later edge.
  task automatic send_item(input mc_frame_t f, input bit may_idle);
    if (may_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= f.cmd;
    frame_scid_i     <= f.scid;
    frame_mc_count_i <= f.count;
    frame_ocf_flag_i <= f.flag;
    frame_vcid_i     <= f.vcid;
    frame_ocf_word_i <= f.word;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    @(negedge clk_i);
  endtask

  // Reprogram all four registers while idle, plus one write to an unused index
  // that must change nothing. Upper data bits get random junk.
  task automatic configure(input logic [SCID_W-1:0] scid, input logic en,
                           input logic [NUM_VC-1:0] mask, input logic sink);
    logic [31:0] rnd;
    rnd = $urandom;
    wait_drain();
    write_reg(CFG_IDX_SPACECRAFT_ID, scid);
    write_reg(CFG_IDX_OCF_ENABLED, {rnd[8:0], en});
    write_reg(CFG_IDX_VC_CONFIGURED_MASK, {rnd[10:9], mask});
    write_reg(CFG_IDX_OCF_SINK_CONNECTED, {rnd[19:11], sink});
    write_reg(CFG_IDX_W'(CFG_IDX_OCF_SINK_CONNECTED + 1 + rnd[21:20]), rnd[31:22]);
    cfg_valid_i <= 1'b0;
    sb.configs++;
  endtask

  initial begin
    int          phase;
    int          n;
    int          pop_pct;
    bit          tx_idle;
    logic [31:0] rnd;

    sb = new();
    @(posedge rst_ni);
    @(negedge clk_i);

    // Directed: reset configuration (ID 0, OCF on, only channel 7, no sink).
    send_item(make_frame(CMD_POP, '1, '1, 1'b1, '1, '1), 1'b0);          // empty pop, junk fields
    send_item(make_frame(CMD_FRAME, 10'd0, 8'd0, 1'b1, 3'd7, '1), 1'b0); // in sequence, queued
    send_item(make_frame(CMD_FRAME, 10'd0, 8'd5, 1'b1, 3'd0, '0), 1'b0); // gap, unknown channel
    send_item(make_frame(CMD_FRAME, 10'h3FF, 8'd6, 1'b1, 3'd7, '1), 1'b0); // foreign spacecraft
    send_item(make_frame(CMD_FRAME, 10'd0, 8'd6, 1'b0, 3'd7, 32'h1234_5678), 1'b0); // no OCF
    send_item(make_frame(CMD_FRAME, 10'd0, 8'd255, 1'b1, 3'd3, 32'hA5A5_A5A5), 1'b0);
    send_item(make_frame(CMD_FRAME, 10'd0, 8'd0, 1'b1, 3'd7, 32'h5A5A_5A5A), 1'b0); // count wrap
    repeat (5) send_item(make_frame(CMD_POP, '0, '0, 1'b0, '0, '0), 1'b0); // drain, then empty

    // Directed: every channel open, sink attached, OCF off.
    configure(10'h3FF, 1'b0, 8'hFF, 1'b1);
    send_item(make_frame(CMD_FRAME, 10'h3FF, 8'd0, 1'b1, 3'd0, '1), 1'b0); // flag mismatch
    send_item(make_frame(CMD_FRAME, 10'h3FF, 8'd1, 1'b0, 3'd5, '0), 1'b0);
    send_item(make_frame(CMD_FRAME, 10'h000, 8'd2, 1'b0, 3'd5, '0), 1'b0); // foreign ID 0
    send_item(make_frame(CMD_POP, '0, '0, 1'b0, '0, '0), 1'b0);

    // Random phases, each with its own configuration and traffic mix.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      rnd     = $urandom;
      tx_idle = 1'b1;
      case (phase)
        0: begin configure(10'h000, 1'b1, 8'h00, 1'b0); pop_pct = 10; end // fill to overflow
        1: begin configure(10'h3FF, 1'b1, 8'hFF, 1'b1); pop_pct = 45; end
        2: begin // long stretch with no idling on either side
          configure(rnd[9:0], 1'b1, rnd[17:10], rnd[18]);
          pop_pct = 55;
          tx_idle = 1'b0;
        end
        3: begin configure(rnd[9:0], 1'b0, rnd[17:10], 1'b1); pop_pct = 40; end
        4: begin configure(rnd[9:0], 1'b1, 8'h80, 1'b0); pop_pct = 70; end // mostly empty
        default: begin configure(rnd[9:0], rnd[19], rnd[17:10], rnd[18]); pop_pct = 30; end
      endcase
      rx_idle = tx_idle;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender once per phase until the pipeline has fully drained.
        if (n == PHASE_ITEMS / 2) wait_drain();
        send_item(random_item(pop_pct), tx_idle);
      end
    end
    rx_idle = 1'b1;

    // Let the last results arrive, then keep watching for anything stray.
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d predicted results never arrived", sb.pending());
      sb.errors++;
    end

    $display("run covered %0d accepted frames (%0d count gaps, %0d OCF overflows) and",
             sb.frames_seen, sb.gaps, sb.overflows);
    $display("%0d pops (%0d on an empty queue) across %0d register settings",
             sb.pops_seen, sb.empty_pops, sb.configs);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: report a fail and stop if the run hangs.
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tmmc_pkg.sv
rtl/tmmc_ram.sv
rtl/tmmc_front.sv
rtl/tmmc_op_fifo.sv
rtl/tmmc_back.sv
rtl/tm_master_channel_rx_checker.sv
bench/tm_master_channel_rx_checker_test.sv
